// File: rtl/wmea_pkg.sv
`default_nettype none
package wmea_pkg;
  localparam int DEF_NUM_CHANNELS = 16;
  localparam int DEF_COUNT_BITS = 16;
  localparam int SAMPLE_W = 24;
  localparam int SUM_W = 40;
  localparam int SQ_W = 64;
  localparam int ERR_W = 23;
  localparam int CH_W = 4;

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  localparam logic [1:0] REG_BOUNDS_ENABLE = 2'd0;
  localparam logic [1:0] REG_LOWER_BOUND   = 2'd1;
  localparam logic [1:0] REG_UPPER_BOUND   = 2'd2;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [15:0] den;
  } div_req_t;
endpackage
`default_nettype wire

// File: rtl/wmea_divider.sv
`default_nettype none
module wmea_divider
  import wmea_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire div_req_t    req,
  output logic             done,
  output logic [63:0]      quotient
);
  // Restoring division, one quotient bit a cycle.
  logic [63:0] num;
  logic [15:0] den;
  logic [16:0] rem;
  logic [6:0]  steps;
  logic        running;
  logic [16:0] trial;
  logic [16:0] shifted;

  always_comb begin
    shifted = {rem[15:0], num[63]};
    trial = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
      steps <= '0;
    end else if (req.start) begin
      running <= 1'b1;
      num <= req.num;
      den <= req.den;
      rem <= '0;
      quotient <= '0;
      steps <= '0;
    end else if (running) begin
      num <= {num[62:0], 1'b0};
      if (!trial[16]) begin
        rem <= trial;
        quotient <= {quotient[62:0], 1'b1};
      end else begin
        rem <= shifted;
        quotient <= {quotient[62:0], 1'b0};
      end
      steps <= steps + 7'd1;
      if (steps == 7'd63) begin
        running <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/windowed_mean_error_accumulator.sv
`default_nettype none
// After an add or clear is accepted, busy is high while the entry is read and written
// back; the next word can be accepted once busy falls.
// A read of an empty channel shows its result once the entry is read; otherwise the result
// follows two divisions, or three divisions and a square root when the variance term is
// positive, all in one shared restoring divider. Busy falls as the result shows.
// One word at a time is in flight; reset clears every entry of the store, busy high.
module windowed_mean_error_accumulator
  import wmea_pkg::*;
#(
  parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            func,
  input  wire logic [CH_W-1:0]       channel,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [SAMPLE_W-1:0]   cfg_data,
  output logic                       strobe,
  output logic [CH_W-1:0]            out_channel,
  output logic [15:0]                sample_count,
  output logic signed [SAMPLE_W-1:0] mean_value,
  output logic [ERR_W-1:0]           mean_error,
  output logic                       overflowed
);
  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [COUNT_BITS-1:0]   cnt;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sq;
    logic                    ovf;
  } entry_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_UPD, S_DIV1, S_DIV2, S_DIFF, S_DIV3, S_SQRT, S_OUT
  } state_t;

  entry_t mem [NUM_CHANNELS];
  entry_t rd_entry;
  entry_t wr_entry;
  logic   wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  state_t state;
  logic [1:0] f_q;
  logic [CH_W-1:0] ch_q;
  logic signed [SAMPLE_W-1:0] s_q;
  logic valid_q;
  logic [AW-1:0] sweep;

  logic bounds_enable;
  logic signed [SAMPLE_W-1:0] lower_bound;
  logic signed [SAMPLE_W-1:0] upper_bound;

  div_req_t dreq;
  logic ddone;
  logic [63:0] dq;

  logic signed [SAMPLE_W-1:0] mean;
  logic signed [47:0] mean_sq;
  logic [63:0] qv;
  logic [63:0] rad;
  logic [31:0] root;
  logic [65:0] srem;
  logic [5:0] sstep;
  logic neg_sum;
  logic [SUM_W-1:0] abs_sum;
  logic signed [47:0] sq_sample;
  logic signed [65:0] dv_next;
  logic [65:0] strial;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_entry;
    rd_entry <= mem[rd_addr];
  end

  assign rd_addr = (state == S_IDLE) ? AW'(channel) : AW'(ch_q);
  assign busy = (state != S_IDLE);
  assign sq_sample = s_q * s_q;
  assign abs_sum = rd_entry.sum[SUM_W-1] ? SUM_W'(-rd_entry.sum) : rd_entry.sum;
  assign mean_sq = mean * mean;
  assign dv_next = $signed({2'b00, qv}) - 66'(mean_sq);
  assign strial = {srem[63:0], rad[63:62]} - {32'd0, root, 2'b01};

  always_comb begin
    wr_en = 1'b0;
    wr_addr = AW'(ch_q);
    wr_entry = rd_entry;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
      wr_addr = sweep;
      wr_entry = '0;
    end else if (state == S_UPD && valid_q) begin
      if (f_q == FUNC_CLEAR) begin
        wr_en = 1'b1;
        wr_entry = '0;
      end else if (f_q == FUNC_ADD &&
                   !(bounds_enable && (s_q < lower_bound || s_q > upper_bound))) begin
        wr_en = 1'b1;
        if (rd_entry.cnt == COUNT_MAX) begin
          wr_entry.ovf = 1'b1;
        end else begin
          wr_entry.cnt = rd_entry.cnt + 1'b1;
          wr_entry.sum = rd_entry.sum + SUM_W'(s_q);
          wr_entry.sq = rd_entry.sq + SQ_W'(sq_sample);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds_enable <= 1'b0;
      lower_bound <= {1'b1, {(SAMPLE_W-1){1'b0}}};
      upper_bound <= {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BOUNDS_ENABLE: bounds_enable <= cfg_data[0];
        REG_LOWER_BOUND:   lower_bound <= cfg_data;
        REG_UPPER_BOUND:   upper_bound <= cfg_data;
        default: ;
      endcase
    end
  end

  wmea_divider u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quotient(dq));

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    dreq.start <= 1'b0;
    if (rst) begin
      state <= S_CLEAR;
      sweep <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (32'(sweep) == NUM_CHANNELS - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            f_q <= func;
            ch_q <= channel;
            s_q <= sample;
            valid_q <= 32'(channel) < NUM_CHANNELS;
            state <= S_RD;
          end
        end
        S_RD: state <= (f_q == FUNC_READ) ? S_UPD : S_UPD;
        S_UPD: begin
          if (f_q == FUNC_READ) begin
            out_channel <= ch_q;
            sample_count <= valid_q ? 16'(rd_entry.cnt) : '0;
            overflowed <= valid_q & rd_entry.ovf;
            mean_value <= '0;
            mean_error <= '0;
            if (valid_q && rd_entry.cnt != '0) begin
              neg_sum <= rd_entry.sum[SUM_W-1];
              dreq.start <= 1'b1;
              dreq.num <= 64'(abs_sum);
              dreq.den <= 16'(rd_entry.cnt);
              state <= S_DIV1;
            end else begin
              strobe <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV1: if (ddone) begin
          mean <= neg_sum ? -SAMPLE_W'(dq) : SAMPLE_W'(dq);
          dreq.start <= 1'b1;
          dreq.num <= rd_entry.sq;
          state <= S_DIV2;
        end
        S_DIV2: if (ddone) begin
          qv <= dq;
          mean_value <= mean;
          state <= S_DIFF;
        end
        S_DIFF: begin
          if (dv_next > 0) begin
            dreq.start <= 1'b1;
            dreq.num <= 64'(dv_next);
            state <= S_DIV3;
          end else begin
            strobe <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DIV3: if (ddone) begin
          rad <= dq;
          root <= '0;
          srem <= '0;
          sstep <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          rad <= {rad[61:0], 2'b00};
          if (!strial[65]) begin
            srem <= strial;
            root <= {root[30:0], 1'b1};
          end else begin
            srem <= {srem[63:0], rad[63:62]};
            root <= {root[30:0], 1'b0};
          end
          sstep <= sstep + 1'b1;
          if (sstep == 6'd31) state <= S_OUT;
        end
        S_OUT: begin
          mean_error <= (root > 32'd8388607) ? 23'h7FFFFF : root[ERR_W-1:0];
          strobe <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(busy));
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start && func == FUNC_ADD) |=> !strobe)
    else $error("add produced a result");
  assert property (@(posedge clk) disable iff (rst)
    strobe && !overflowed && sample_count == 16'd0 |-> mean_value == '0 && mean_error == '0)
    else $error("empty channel gave nonzero statistics");
endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
module tb
  import wmea_pkg::*;
();

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int CHANNELS = DEF_NUM_CHANNELS;
  localparam longint COUNT_LIMIT = (64'd1 << DEF_COUNT_BITS) - 1;
  localparam longint ERR_LIMIT = 8388607;

  typedef struct packed {
    logic [CH_W-1:0] chan;
    logic [15:0] count;
    logic [SAMPLE_W-1:0] mean;
    logic [ERR_W-1:0] err;
    logic ovf;
  } stats_t;

  typedef struct {
    logic [1:0] op;
    int chan;
    int value;
    bit typed;
    stats_t want;
  } row_t;

  logic clk, rst, start, cfg_we;
  logic [1:0] func, cfg_index;
  logic [CH_W-1:0] channel;
  logic signed [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] cfg_data;
  wire busy, strobe, overflowed;
  wire [CH_W-1:0] out_channel;
  wire [15:0] sample_count;
  wire signed [SAMPLE_W-1:0] mean_value;
  wire [ERR_W-1:0] mean_error;

  windowed_mean_error_accumulator u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .channel(channel), .sample(sample), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .strobe(strobe), .out_channel(out_channel),
    .sample_count(sample_count), .mean_value(mean_value), .mean_error(mean_error),
    .overflowed(overflowed)
  );

  longint unsigned acc_count[CHANNELS];
  longint acc_sum[CHANNELS];
  longint unsigned acc_square[CHANNELS];
  bit acc_ovf[CHANNELS];
  bit window_on;
  longint window_lo, window_hi;

  stats_t pending_stats[$];
  int mismatches;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, trial;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= x) r = trial;
    end
    return r;
  endfunction

  // Applies one accepted word to the model state; returns 1 when a read result follows.
  function automatic bit apply_word(logic [1:0] op, int chan, logic signed [23:0] s,
                                    output stats_t res);
    longint sv, mean, q, d;
    longint unsigned n, e;
    sv = s;
    res = '0;
    if (op == FUNC_ADD) begin
      if (window_on && (sv < window_lo || sv > window_hi)) return 0;
      if (acc_count[chan] >= COUNT_LIMIT) begin
        acc_ovf[chan] = 1;
        return 0;
      end
      acc_count[chan]++;
      acc_sum[chan] += sv;
      acc_square[chan] += sv * sv;
      return 0;
    end
    if (op == FUNC_CLEAR) begin
      acc_count[chan] = 0;
      acc_sum[chan] = 0;
      acc_square[chan] = 0;
      acc_ovf[chan] = 0;
      return 0;
    end
    if (op != FUNC_READ) return 0;
    n = acc_count[chan];
    mean = 0;
    e = 0;
    if (n > 0) begin
      q = longint'(acc_square[chan] / n);
      mean = acc_sum[chan] / longint'(n);
      d = q - mean * mean;
      if (d > 0) begin
        e = int_sqrt(longint'(unsigned'(d)) / n);
        if (e > ERR_LIMIT) e = ERR_LIMIT;
      end
    end
    res.chan = chan[CH_W-1:0];
    res.count = n[15:0];
    res.mean = mean[23:0];
    res.err = e[22:0];
    res.ovf = acc_ovf[chan];
    return 1;
  endfunction

  task automatic send_word(logic [1:0] op, int chan, logic signed [23:0] s, bit keep,
                           bit typed = 0, stats_t want = '0);
    stats_t res;
    start <= 1'b1;
    func <= op;
    channel <= chan[CH_W-1:0];
    sample <= s;
    do @(posedge clk); while (busy);
    if (apply_word(op, chan, s, res)) pending_stats = {pending_stats, (typed ? want : res)};
    if (!keep) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == REG_BOUNDS_ENABLE) window_on = data[0];
    else if (idx == REG_LOWER_BOUND) window_lo = longint'(signed'(data));
    else if (idx == REG_UPPER_BOUND) window_hi = longint'(signed'(data));
  endtask

  task automatic set_window(bit en, int lo, int hi);
    wait_idle();
    write_reg(REG_BOUNDS_ENABLE, {23'd0, en});
    write_reg(REG_LOWER_BOUND, lo[23:0]);
    write_reg(REG_UPPER_BOUND, hi[23:0]);
    write_reg(REG_SPARE, 24'($urandom));
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [23:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 24'($urandom);
    if (r < 8) return 24'(int'($urandom_range(0, 1023)) - 512);
    if (r == 8) return 24'(8388607 - int'($urandom_range(0, 3)));
    return 24'(-8388608 + int'($urandom_range(0, 3)));
  endfunction

  task automatic random_words(int total);
    int left, burst, r;
    logic [1:0] op;
    left = total;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      if (burst > left) burst = left;
      for (int k = 0; k < burst; k++) begin
        r = $urandom_range(0, 99);
        op = r < 60 ? FUNC_ADD : r < 85 ? FUNC_READ : r < 95 ? FUNC_CLEAR : FUNC_UNUSED;
        send_word(op, int'($urandom_range(0, CHANNELS - 1)), pick_sample(), k < burst - 1);
      end
      left -= burst;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    stats_t got, want;
    if (!rst && strobe) begin
      got = {out_channel, sample_count, mean_value, mean_error, overflowed};
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word: %p", got);
      end else begin
        want = pending_stats[0];
        pending_stats.delete(0);
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  row_t rows[$];

  function automatic row_t mk(logic [1:0] op, int chan, int value, bit typed = 0,
                              stats_t want = '0);
    row_t r;
    r.op = op;
    r.chan = chan;
    r.value = value;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  initial begin
    stats_t res;
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_ADD;
    channel = '0;
    sample = '0;
    cfg_we = 1'b0;
    cfg_index = REG_BOUNDS_ENABLE;
    cfg_data = '0;
    mismatches = 0;
    window_on = 0;
    window_lo = -8388608;
    window_hi = 8388607;
    for (int i = 0; i < CHANNELS; i++) begin
      acc_count[i] = 0;
      acc_sum[i] = 0;
      acc_square[i] = 0;
      acc_ovf[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    rows = {rows, mk(FUNC_READ, 0, 0, 1, '{4'd0, 16'd0, 24'd0, 23'd0, 1'b0})};
    rows = {rows, mk(FUNC_READ, 15, 0, 1, '{4'd15, 16'd0, 24'd0, 23'd0, 1'b0})};
    rows = {rows, mk(FUNC_ADD, 1, 8388607)};
    rows = {rows, mk(FUNC_ADD, 1, -8388608)};
    rows = {rows, mk(FUNC_READ, 1, 0)};
    rows = {rows, mk(FUNC_ADD, 2, 256)};
    rows = {rows, mk(FUNC_ADD, 2, 768)};
    rows = {rows, mk(FUNC_ADD, 2, -1)};
    rows = {rows, mk(FUNC_READ, 2, 0)};
    rows = {rows, mk(FUNC_CLEAR, 2, 0)};
    rows = {rows, mk(FUNC_READ, 2, 0, 1, '{4'd2, 16'd0, 24'd0, 23'd0, 1'b0})};
    rows = {rows, mk(FUNC_UNUSED, 3, 5)};
    rows = {rows, mk(FUNC_READ, 3, 0, 1, '{4'd3, 16'd0, 24'd0, 23'd0, 1'b0})};
    rows = {rows, mk(FUNC_ADD, 4, 8388607)};
    rows = {rows, mk(FUNC_READ, 4, 0, 1, '{4'd4, 16'd1, 24'h7FFFFF, 23'd0, 1'b0})};
    rows = {rows, mk(FUNC_ADD, 15, -8388608)};
    rows = {rows, mk(FUNC_ADD, 15, 0)};
    rows = {rows, mk(FUNC_READ, 15, 0)};
    foreach (rows[i])
      send_word(rows[i].op, rows[i].chan, rows[i].value[23:0], $urandom_range(0, 1) == 1,
                rows[i].typed, rows[i].want);
    random_words(300);

    set_window(1, -256, 256);
    random_words(300);
    set_window(1, 1000, -1000);
    random_words(250);
    set_window(1, 0, 0);
    random_words(250);
    set_window(1, -8388608, 8388607);
    random_words(300);
    set_window(0, -8388608, 8388607);
    random_words(300);

    send_word(FUNC_CLEAR, 5, 0, 1);
    send_word(FUNC_READ, 5, 0, 0);

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
